[hdl/olid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list package
// Shared sizes, operation codes and status codes of the ordered list block.
// ----------------------------------------------------------------------------
package olid_pkg;

  // Store capacity and the widths that follow from it.
  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the item ports.
  localparam int DATA_W      = 32;
  localparam int POS_W       = 8;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 8;

  // Width wide enough to compare a position against the count plus one.
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Status codes returned with each result item.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_POS   = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_EMPTY     = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

endpackage

[hdl/olid_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olid_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ordered_list_insert_delete.sv]
`timescale 1ns / 1ps
// Each item passes through the sequencer states and then the output register; insert
// and delete walk the store entry by entry, and errors go straight to the done state.
// One item at a time: the next item is taken once the sequencer is idle.
// This is set by the single RAM port pair, walked with two sequencer states per entry.
// Reset clears the count and the control state at once; the store needs no clearing
// pass, as no entry at or above the count is ever read.
// ----------------------------------------------------------------------------
// Ordered list with insert, delete and read
// Keeps an ordered list of signed 32-bit entries in a RAM, with a count, and
// shifts entries one RAM access at a time under a small sequencer.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic        [olid_pkg::KIND_W-1:0]       kind_i,
  input  logic signed [olid_pkg::DATA_W-1:0]       value_i,
  input  logic        [olid_pkg::POS_W-1:0]        position_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic        [olid_pkg::STATUS_W-1:0]     status_o,
  output logic signed [olid_pkg::DATA_W-1:0]       read_value_o,
  output logic        [olid_pkg::COUNT_OUT_W-1:0]  entry_count_o
);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_INS_RD  = 9'b000000010,
    ST_INS_WR  = 9'b000000100,
    ST_DEL_RD  = 9'b000001000,
    ST_DEL_CMP = 9'b000010000,
    ST_SH_RD   = 9'b000100000,
    ST_SH_WR   = 9'b001000000,
    ST_RD_WAIT = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_e;

  state_e                         state_q, state_d;
  logic [olid_pkg::CNT_W-1:0]     count_q, count_d;
  logic [olid_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [olid_pkg::CNT_W-1:0]     tgt_q, tgt_d;
  logic [olid_pkg::DATA_W-1:0]    val_q, val_d;
  olid_pkg::status_e              res_status_q, res_status_d;
  logic [olid_pkg::DATA_W-1:0]    res_value_q, res_value_d;

  logic                           out_valid_q;
  olid_pkg::status_e              out_status_q;
  logic [olid_pkg::DATA_W-1:0]    out_value_q;
  logic [olid_pkg::CNT_W-1:0]     out_count_q;

  logic                           ram_we;
  logic [olid_pkg::ADDR_W-1:0]    ram_waddr;
  logic [olid_pkg::DATA_W-1:0]    ram_wdata;
  logic [olid_pkg::ADDR_W-1:0]    ram_raddr;
  logic [olid_pkg::DATA_W-1:0]    ram_rdata;

  logic                           accept;
  logic                           out_free;
  logic                           load_out;
  logic [olid_pkg::CNT_W-1:0]     idx_inc;
  logic [olid_pkg::CNT_W-1:0]     idx_dec;
  logic [olid_pkg::CMP_W-1:0]     pos_ext;
  logic [olid_pkg::CMP_W-1:0]     cnt_ext;
  logic [olid_pkg::CMP_W-1:0]     pos_dec;

  // Entry store.
  olid_ram #(
    .DATA_W (olid_pkg::DATA_W),
    .DEPTH  (olid_pkg::CAPACITY),
    .ADDR_W (olid_pkg::ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and helper arithmetic.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == ST_DONE) && out_free;
  assign idx_inc    = idx_q + olid_pkg::CNT_W'(1);
  assign idx_dec    = idx_q - olid_pkg::CNT_W'(1);
  assign pos_ext    = olid_pkg::CMP_W'(position_i);
  assign cnt_ext    = olid_pkg::CMP_W'(count_q);
  assign pos_dec    = pos_ext - olid_pkg::CMP_W'(1);

  // Sequencer: decode in idle, then walk the store one entry at a time, two states per entry.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    tgt_d        = tgt_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[olid_pkg::ADDR_W-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_q[olid_pkg::ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d        = value_i;
          tgt_d        = olid_pkg::CNT_W'(pos_dec);
          res_value_d  = '0;
          res_status_d = olid_pkg::STATUS_OK;
          state_d      = ST_DONE;
          if (kind_i == olid_pkg::KIND_INSERT) begin
            if ((pos_ext == '0) || (pos_ext > cnt_ext + olid_pkg::CMP_W'(1))) begin
              res_status_d = olid_pkg::STATUS_BAD_POS;
            end else if (count_q == olid_pkg::CNT_W'(olid_pkg::CAPACITY)) begin
              res_status_d = olid_pkg::STATUS_FULL;
            end else begin
              idx_d   = count_q;
              state_d = ST_INS_RD;
            end
          end else if (kind_i == olid_pkg::KIND_DELETE) begin
            if (count_q == '0) begin
              res_status_d = olid_pkg::STATUS_EMPTY;
            end else begin
              idx_d   = '0;
              state_d = ST_DEL_RD;
            end
          end else if (kind_i == olid_pkg::KIND_READ) begin
            if (count_q == '0) begin
              res_status_d = olid_pkg::STATUS_EMPTY;
            end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
              res_status_d = olid_pkg::STATUS_BAD_POS;
            end else begin
              ram_raddr = olid_pkg::ADDR_W'(pos_dec);
              state_d   = ST_RD_WAIT;
            end
          end
        end
      end

      // Insert: move entries up from the top until the target slot is free.
      ST_INS_RD: begin
        if (idx_q == tgt_q) begin
          ram_we       = 1'b1;
          ram_wdata    = val_q;
          count_d      = count_q + olid_pkg::CNT_W'(1);
          res_status_d = olid_pkg::STATUS_OK;
          state_d      = ST_DONE;
        end else begin
          ram_raddr = idx_dec[olid_pkg::ADDR_W-1:0];
          state_d   = ST_INS_WR;
        end
      end

      ST_INS_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_dec;
        state_d = ST_INS_RD;
      end

      // Delete: search for the first matching entry.
      ST_DEL_RD: begin
        state_d = ST_DEL_CMP;
      end

      ST_DEL_CMP: begin
        if (ram_rdata == val_q) begin
          state_d = ST_SH_RD;
        end else if (idx_inc == count_q) begin
          res_status_d = olid_pkg::STATUS_NOT_FOUND;
          state_d      = ST_DONE;
        end else begin
          idx_d   = idx_inc;
          state_d = ST_DEL_RD;
        end
      end

      // Delete: move the later entries down by one.
      ST_SH_RD: begin
        if (idx_inc >= count_q) begin
          count_d      = count_q - olid_pkg::CNT_W'(1);
          res_status_d = olid_pkg::STATUS_OK;
          state_d      = ST_DONE;
        end else begin
          ram_raddr = idx_inc[olid_pkg::ADDR_W-1:0];
          state_d   = ST_SH_WR;
        end
      end

      ST_SH_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = ST_SH_RD;
      end

      ST_RD_WAIT: begin
        res_value_d  = ram_rdata;
        res_status_d = olid_pkg::STATUS_OK;
        state_d      = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    tgt_q        <= tgt_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = $signed(out_value_q);
  assign entry_count_o = olid_pkg::COUNT_OUT_W'(out_count_q);

`ifndef SYNTHESIS
  // The count never grows beyond the capacity of the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olid_pkg::CNT_W'(olid_pkg::CAPACITY))
    else $error("count exceeds capacity");

  // An accepted item keeps the input side stalled in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting an item");

  // A non-zero read value only comes with a successful status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_value_o != '0)) |-> (status_o == olid_pkg::STATUS_OK))
    else $error("read value returned with an error status");

  // The sequencer state stays one-hot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state is not one-hot");
`endif

endmodule
